### rtl/sg_descriptor_builder_assert.svh
// Assertion macros shared by the descriptor builder RTL.
`ifndef SG_DESCRIPTOR_BUILDER_ASSERT_SVH
`define SG_DESCRIPTOR_BUILDER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SGD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SGD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sgd_pkg.sv
// Types and codes of the scatter-gather descriptor builder.
package sgd_pkg;

  localparam int ADDR_W = 48;
  localparam int LEN_W  = 32;
  localparam int OFF_W  = 32;
  localparam int CNT_REG_W = 5;

  typedef enum logic [1:0] {
    CMD_LOAD_DATA = 2'd0,
    CMD_LOAD_DESC = 2'd1,
    CMD_ADD       = 2'd2,
    CMD_CLEAR     = 2'd3
  } sgd_cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_SIZE = 2'd1,
    ST_DATA_FULL = 2'd2,
    ST_DESC_FULL = 2'd3
  } sgd_status_e;

  localparam logic CFG_DATA_COUNT = 1'b0;
  localparam logic CFG_DESC_COUNT = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
  } sgd_seg_t;

  typedef struct packed {
    sgd_cmd_e          cmd;
    logic [3:0]        seg_index;
    logic [ADDR_W-1:0] seg_addr;
    logic [LEN_W-1:0]  seg_len;
    logic [LEN_W-1:0]  req_size;
  } sgd_req_t;

  typedef struct packed {
    sgd_status_e       status;
    logic [ADDR_W-1:0] buf_addr;
    logic [LEN_W-1:0]  buf_len;
    logic [OFF_W-1:0]  buf_offset;
    logic [OFF_W-1:0]  desc_offset;
    logic              sof;
    logic              eof;
    logic              last;
  } sgd_res_t;

endpackage

### rtl/sgd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sgd_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/sg_descriptor_builder.sv
// Scatter-gather descriptor builder: segment tables, offset walk and result output.
//
//  channel   handshake             payload
//  request   start_i / busy_o      req_i   (sgd_req_t)
//  result    result_valid_o        result_o (sgd_res_t), one cycle per result
//  config    cfg_we_i / cfg_idx_i  cfg_wdata_i
//
// Loads and clears finish without leaving idle; a zero-size add gives its error result the next cycle.
// Other adds run twice over the tables, a planning pass then an emitting pass; each
// table entry visited takes a RAM read state then an evaluate state, and every slot
// search restarts at descriptor entry 0.
// Offsets reset to zero; the tables need no clearing. Results cannot be stalled.
module sg_descriptor_builder
  import sgd_pkg::*;
#(
  parameter int MAX_SEGMENTS = 16,
  parameter int DESC_BYTES   = 52,
  parameter int DESC_ALIGN   = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  sgd_req_t             req_i,
  output logic                 result_valid_o,
  output sgd_res_t             result_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CNT_REG_W-1:0] cfg_wdata_i
);

  `include "sg_descriptor_builder_assert.svh"

  localparam int IDX_W   = MAX_SEGMENTS > 1 ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int DOFF_W  = OFF_W + 2;
  localparam int SOFF_W  = LEN_W + CNT_W + 2;
  localparam int ALB     = $clog2(DESC_ALIGN);
  localparam int SEG_W   = ADDR_W + LEN_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DLOC_RD, S_DLOC_EV, S_SLOC_RD, S_SLOC_EV, S_SLOT_RD, S_SLOT_EV,
    S_PIECE, S_DNEXT_RD, S_DNEXT_EV
  } state_e;

  state_e state_q;
  logic [CNT_REG_W-1:0] data_cnt_q, desc_cnt_q;
  logic [OFF_W-1:0]  next_data_q, next_desc_q;
  logic              pass_q;
  logic [LEN_W-1:0]  req_size_q, sz_q;
  logic [CNT_W-1:0]  i_q, j_q, cnt_q;
  logic [DOFF_W-1:0] off_q, inside_q, doff_q, soff_q;
  logic [ADDR_W-1:0] daddr_q;
  logic [LEN_W-1:0]  dlen_q;
  logic [SOFF_W-1:0] base_q, sr_q, dinside_q, slot_q;

  logic              accept, ram_we_data, ram_we_desc, idx_ok;
  logic [IDX_W-1:0]  waddr;
  sgd_seg_t          wseg, d_ent, s_ent;
  logic [SEG_W-1:0]  d_raw, s_raw;
  logic [CNT_W-1:0]  ndata, ndesc;
  logic [ADDR_W-1:0] pa;
  logic [ALB-1:0]    rem;
  logic [SOFF_W-1:0] adj, inside2, slot_end;
  logic              fits, last_piece;
  logic [LEN_W-1:0]  space, piece;
  logic [DOFF_W-1:0] doff_new;
  logic              slot_ovf, data_ovf, run_out;

  function automatic sgd_res_t err_res(sgd_status_e code);
    sgd_res_t r;
    r        = '0;
    r.status = code;
    r.last   = 1'b1;
    return r;
  endfunction

  assign accept      = start_i && !busy_o;
  assign idx_ok      = 32'(req_i.seg_index) < MAX_SEGMENTS;
  assign ram_we_data = accept && req_i.cmd == CMD_LOAD_DATA && idx_ok;
  assign ram_we_desc = accept && req_i.cmd == CMD_LOAD_DESC && idx_ok;
  assign waddr       = IDX_W'(req_i.seg_index);
  assign wseg        = '{addr: req_i.seg_addr, len: req_i.seg_len};
  assign busy_o      = state_q != S_IDLE;

  sgd_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS)) u_data_tab (
    .clk_i, .we_i(ram_we_data), .waddr_i(waddr), .wdata_i(wseg),
    .raddr_i(i_q[IDX_W-1:0]), .rdata_o(d_raw)
  );

  sgd_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS)) u_desc_tab (
    .clk_i, .we_i(ram_we_desc), .waddr_i(waddr), .wdata_i(wseg),
    .raddr_i(j_q[IDX_W-1:0]), .rdata_o(s_raw)
  );

  always_comb begin
    d_ent = sgd_seg_t'(d_raw);
    s_ent = sgd_seg_t'(s_raw);
    ndata = (32'(data_cnt_q) > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS) : CNT_W'(data_cnt_q);
    ndesc = (32'(desc_cnt_q) > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS) : CNT_W'(desc_cnt_q);
    // Slot search: round the physical address up to the alignment, then check room.
    pa       = s_ent.addr + ADDR_W'(dinside_q);
    rem      = pa[ALB-1:0];
    adj      = (rem == '0) ? '0 : SOFF_W'(DESC_ALIGN) - SOFF_W'(rem);
    inside2  = dinside_q + adj;
    fits     = inside2 + SOFF_W'(DESC_BYTES) <= SOFF_W'(s_ent.len);
    slot_end = slot_q + SOFF_W'(DESC_BYTES);
    space      = dlen_q - LEN_W'(inside_q);
    last_piece = space >= sz_q;
    piece      = last_piece ? sz_q : space;
    doff_new   = doff_q + DOFF_W'(piece);
    slot_ovf   = slot_end > SOFF_W'({OFF_W{1'b1}});
    data_ovf   = doff_new > DOFF_W'({OFF_W{1'b1}});
    run_out    = 32'(i_q) + 1 >= 32'(ndata) || 32'(cnt_q) + 1 >= MAX_SEGMENTS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      data_cnt_q     <= '0;
      desc_cnt_q     <= '0;
      next_data_q    <= '0;
      next_desc_q    <= '0;
      pass_q         <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_DATA_COUNT) data_cnt_q <= cfg_wdata_i;
        else                             desc_cnt_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_IDLE: begin
          result_valid_o <= accept && req_i.cmd == CMD_ADD && req_i.req_size == '0;
          if (accept) begin
            if (req_i.cmd == CMD_CLEAR) begin
              next_data_q <= '0;
              next_desc_q <= '0;
            end else if (req_i.cmd == CMD_ADD) begin
              if (req_i.req_size == '0) begin
                result_o <= err_res(ST_ZERO_SIZE);
              end else begin
                req_size_q <= req_i.req_size;
                sz_q       <= req_i.req_size;
                pass_q     <= 1'b0;
                i_q        <= '0;
                cnt_q      <= '0;
                off_q      <= DOFF_W'(next_data_q);
                doff_q     <= DOFF_W'(next_data_q);
                soff_q     <= DOFF_W'(next_desc_q);
                state_q    <= S_DLOC_RD;
              end
            end
          end
        end
        S_DLOC_RD: begin
          result_valid_o <= i_q >= ndata;
          if (i_q >= ndata) begin
            result_o <= err_res(ST_DATA_FULL);
            state_q  <= S_IDLE;
          end else begin
            state_q <= S_DLOC_EV;
          end
        end
        S_DLOC_EV: begin
          result_valid_o <= 1'b0;
          if (off_q >= DOFF_W'(d_ent.len)) begin
            off_q   <= off_q - DOFF_W'(d_ent.len);
            i_q     <= i_q + CNT_W'(1);
            state_q <= S_DLOC_RD;
          end else begin
            inside_q <= off_q;
            daddr_q  <= d_ent.addr;
            dlen_q   <= d_ent.len;
            j_q      <= '0;
            base_q   <= '0;
            sr_q     <= SOFF_W'(soff_q);
            state_q  <= S_SLOC_RD;
          end
        end
        S_SLOC_RD, S_SLOT_RD: begin
          result_valid_o <= j_q >= ndesc;
          if (j_q >= ndesc) begin
            result_o <= err_res(ST_DESC_FULL);
            state_q  <= S_IDLE;
          end else begin
            state_q <= (state_q == S_SLOC_RD) ? S_SLOC_EV : S_SLOT_EV;
          end
        end
        S_SLOC_EV: begin
          result_valid_o <= 1'b0;
          if (sr_q >= SOFF_W'(s_ent.len)) begin
            sr_q    <= sr_q - SOFF_W'(s_ent.len);
            base_q  <= base_q + SOFF_W'(s_ent.len);
            j_q     <= j_q + CNT_W'(1);
            state_q <= S_SLOC_RD;
          end else begin
            dinside_q <= sr_q;
            state_q   <= S_SLOT_RD;
          end
        end
        S_SLOT_EV: begin
          result_valid_o <= 1'b0;
          if (fits) begin
            slot_q  <= base_q + inside2;
            state_q <= S_PIECE;
          end else begin
            // The aligned spot ran past this segment end: go on to the next one.
            base_q    <= base_q + SOFF_W'(s_ent.len);
            dinside_q <= '0;
            j_q       <= j_q + CNT_W'(1);
            state_q   <= S_SLOT_RD;
          end
        end
        S_PIECE: begin
          result_valid_o <= slot_ovf || pass_q || (last_piece ? data_ovf : run_out);
          if (slot_ovf) begin
            result_o <= err_res(ST_DESC_FULL);
            state_q  <= S_IDLE;
          end else begin
            if (pass_q) begin
              result_o.status      <= ST_OK;
              result_o.buf_addr    <= daddr_q + ADDR_W'(inside_q);
              result_o.buf_len     <= piece;
              result_o.buf_offset  <= next_data_q;
              result_o.desc_offset <= slot_q[OFF_W-1:0];
              result_o.sof         <= cnt_q == '0;
              result_o.eof         <= last_piece;
              result_o.last        <= last_piece;
            end
            cnt_q    <= cnt_q + CNT_W'(1);
            soff_q   <= DOFF_W'(slot_end);
            inside_q <= '0;
            doff_q   <= doff_new;
            if (last_piece) begin
              if (pass_q) begin
                next_data_q <= doff_new[OFF_W-1:0];
                next_desc_q <= slot_end[OFF_W-1:0];
                state_q     <= S_IDLE;
              end else if (data_ovf) begin
                result_o <= err_res(ST_DATA_FULL);
                state_q  <= S_IDLE;
              end else begin
                // The plan fits: run the same walk again and emit it.
                pass_q  <= 1'b1;
                sz_q    <= req_size_q;
                i_q     <= '0;
                cnt_q   <= '0;
                off_q   <= DOFF_W'(next_data_q);
                doff_q  <= DOFF_W'(next_data_q);
                soff_q  <= DOFF_W'(next_desc_q);
                state_q <= S_DLOC_RD;
              end
            end else begin
              sz_q <= sz_q - space;
              i_q  <= i_q + CNT_W'(1);
              if (run_out) begin
                result_o <= err_res(ST_DATA_FULL);
                state_q  <= S_IDLE;
              end else begin
                state_q <= S_DNEXT_RD;
              end
            end
          end
        end
        S_DNEXT_RD: begin
          result_valid_o <= 1'b0;
          state_q        <= S_DNEXT_EV;
        end
        S_DNEXT_EV: begin
          result_valid_o <= 1'b0;
          daddr_q <= d_ent.addr;
          dlen_q  <= d_ent.len;
          j_q     <= '0;
          base_q  <= '0;
          sr_q    <= SOFF_W'(soff_q);
          state_q <= S_SLOC_RD;
        end
        default: begin
          result_valid_o <= 1'b0;
          state_q        <= S_IDLE;
        end
      endcase
    end
  end

  `SGD_ASSERT_IMP(a_err_is_last, result_valid_o && result_o.status != ST_OK,
                  result_o.last && !result_o.sof, "error result not marked last")
  `SGD_ASSERT_IMP(a_ok_from_walk, result_valid_o && result_o.status == ST_OK,
                  $past(busy_o), "ok result without a table walk")
  `SGD_ASSERT_NXT(a_add_starts_walk,
                  accept && req_i.cmd == CMD_ADD && req_i.req_size != '0,
                  busy_o, "add request did not start a walk")
  `SGD_ASSERT_IMP(a_eof_last, result_valid_o, result_o.eof == (result_o.last &&
                  result_o.status == ST_OK), "eof and last disagree")

endmodule

### bench/sg_descriptor_builder_checker.sv
// Checker for the descriptor builder: predicts each request's results and compares them.
module sg_descriptor_builder_checker
  import sgd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  sgd_req_t             req_i,
  input  logic                 result_valid_i,
  input  sgd_res_t             result_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CNT_REG_W-1:0] cfg_wdata_i,
  output int                   pending_o,
  output int                   errors_o
);

  localparam int          SEG_DEPTH  = 16;
  localparam logic [63:0] SLOT_BYTES = 64'd52;
  localparam logic [63:0] SLOT_ALIGN = 64'd64;
  localparam logic [63:0] MASK48     = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] MASK32     = 64'hFFFF_FFFF;

  logic [63:0] data_addr[SEG_DEPTH];
  logic [63:0] data_len[SEG_DEPTH];
  logic [63:0] area_addr[SEG_DEPTH];
  logic [63:0] area_len[SEG_DEPTH];
  logic [4:0]  data_count;
  logic [4:0]  area_count;
  logic [63:0] data_cursor;
  logic [63:0] area_cursor;
  sgd_res_t    expected_q[$];
  int          mismatches;

  initial begin
    for (int i = 0; i < SEG_DEPTH; i++) begin
      data_addr[i] = '0;
      data_len[i]  = '0;
      area_addr[i] = '0;
      area_len[i]  = '0;
    end
    mismatches = 0;
  end

  function automatic int clamp_count(logic [4:0] c);
    return (c > SEG_DEPTH) ? SEG_DEPTH : int'(c);
  endfunction

  // Walks a table to the entry that holds virtual byte off_in.
  function automatic bit find_entry(input bit area, input int n, input logic [63:0] off_in,
                                    output int ind, output logic [63:0] seg_pos);
    logic [63:0] off;
    logic [63:0] l;
    off = off_in;
    ind = 0;
    seg_pos = '0;
    for (int i = 0; i < n; i++) begin
      l = area ? area_len[i] : data_len[i];
      if (off >= l) begin
        off = off - l;
      end else begin
        ind = i;
        seg_pos = off;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Next aligned slot that holds a whole descriptor at or after off_in.
  function automatic bit find_desc_slot(input logic [63:0] off_in, output logic [63:0] slot);
    int          n;
    int          ind;
    logic [63:0] off;
    logic [63:0] seg_pos;
    logic [63:0] pa;
    logic [63:0] rem;
    logic [63:0] len;
    n = clamp_count(area_count);
    off = off_in;
    slot = '0;
    if (!find_entry(1'b1, n, off, ind, seg_pos)) return 1'b0;
    while (ind < n) begin
      pa  = (area_addr[ind] + seg_pos) & MASK48;
      rem = pa % SLOT_ALIGN;
      len = area_len[ind];
      if (rem != 0) begin
        off     = off + SLOT_ALIGN - rem;
        seg_pos = seg_pos + SLOT_ALIGN - rem;
      end
      if (seg_pos <= len && SLOT_BYTES <= len - seg_pos) begin
        slot = off;
        return 1'b1;
      end
      off = off - seg_pos + len;
      seg_pos = '0;
      ind++;
    end
    return 1'b0;
  endfunction

  function automatic void push_error(sgd_status_e code);
    sgd_res_t r;
    r = '0;
    r.status = code;
    r.last = 1'b1;
    expected_q.push_back(r);
  endfunction

  function automatic void plan_request(sgd_req_t r);
    sgd_res_t    pieces[SEG_DEPTH];
    int          cnt;
    int          n;
    int          ind;
    logic [63:0] sz;
    logic [63:0] seg_pos;
    logic [63:0] doff;
    logic [63:0] soff;
    logic [63:0] slot;
    logic [63:0] space;
    logic [63:0] piece;
    cnt = 0;
    case (r.cmd)
      CMD_LOAD_DATA: begin
        data_addr[r.seg_index] = 64'(r.seg_addr);
        data_len[r.seg_index]  = 64'(r.seg_len);
      end
      CMD_LOAD_DESC: begin
        area_addr[r.seg_index] = 64'(r.seg_addr);
        area_len[r.seg_index]  = 64'(r.seg_len);
      end
      CMD_CLEAR: begin
        data_cursor = '0;
        area_cursor = '0;
      end
      default: begin
        sz = 64'(r.req_size);
        if (sz == 0) begin
          push_error(ST_ZERO_SIZE);
          return;
        end
        n = clamp_count(data_count);
        doff = data_cursor;
        soff = area_cursor;
        if (!find_entry(1'b0, n, doff, ind, seg_pos)) begin
          push_error(ST_DATA_FULL);
          return;
        end
        forever begin
          space = data_len[ind] - seg_pos;
          if (!find_desc_slot(soff, slot) || slot + SLOT_BYTES > MASK32) begin
            push_error(ST_DESC_FULL);
            return;
          end
          piece = (space < sz) ? space : sz;
          pieces[cnt] = '0;
          pieces[cnt].status      = ST_OK;
          pieces[cnt].buf_addr    = ADDR_W'((data_addr[ind] + seg_pos) & MASK48);
          pieces[cnt].buf_len     = LEN_W'(piece);
          pieces[cnt].buf_offset  = OFF_W'(data_cursor);
          pieces[cnt].desc_offset = OFF_W'(slot);
          pieces[cnt].sof         = (cnt == 0);
          cnt++;
          soff = slot + SLOT_BYTES;
          seg_pos = '0;
          doff = doff + piece;
          if (space >= sz) break;
          sz = sz - space;
          ind++;
          if (ind >= n || cnt >= SEG_DEPTH) begin
            push_error(ST_DATA_FULL);
            return;
          end
        end
        if (doff > MASK32) begin
          push_error(ST_DATA_FULL);
          return;
        end
        pieces[cnt-1].eof  = 1'b1;
        pieces[cnt-1].last = 1'b1;
        for (int k = 0; k < cnt; k++) expected_q.push_back(pieces[k]);
        data_cursor = doff;
        area_cursor = soff;
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  task automatic compare_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sgd_res_t want;
    if (!rst_ni) begin
      data_count  <= '0;
      area_count  <= '0;
      data_cursor <= '0;
      area_cursor <= '0;
      expected_q.delete();
      pending_o   <= 0;
      errors_o    <= 0;
    end else begin
      if (result_valid_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", 64'(result_i), '0);
        end else begin
          want = expected_q.pop_front();
          compare_field("status", 64'(result_i.status), 64'(want.status));
          compare_field("buf_addr", 64'(result_i.buf_addr), 64'(want.buf_addr));
          compare_field("buf_len", 64'(result_i.buf_len), 64'(want.buf_len));
          compare_field("buf_offset", 64'(result_i.buf_offset), 64'(want.buf_offset));
          compare_field("desc_offset", 64'(result_i.desc_offset), 64'(want.desc_offset));
          compare_field("sof", 64'(result_i.sof), 64'(want.sof));
          compare_field("eof", 64'(result_i.eof), 64'(want.eof));
          compare_field("last", 64'(result_i.last), 64'(want.last));
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_DATA_COUNT) data_count <= cfg_wdata_i;
        else                              area_count <= cfg_wdata_i;
      end
      // Cursors are updated blocking inside the planner, so they stay variables.
      if (start_i && !busy_i) plan_request(req_i);
      pending_o <= expected_q.size();
      errors_o  <= mismatches;
    end
  end

endmodule

### bench/sg_descriptor_builder_tb.sv
// Top of the descriptor builder testbench: clock, reset, request stimulus and verdict.
module sg_descriptor_builder_tb;
  import sgd_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i;
  logic                 busy_o;
  sgd_req_t             req_i;
  logic                 result_valid_o;
  sgd_res_t             result_o;
  logic                 cfg_we_i;
  logic                 cfg_idx_i;
  logic [CNT_REG_W-1:0] cfg_wdata_i;
  int                   pending;
  int                   errors;
  int                   quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  sg_descriptor_builder uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .result_valid_o, .result_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  sg_descriptor_builder_checker checker_i (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .req_i, .result_valid_i(result_valid_o),
    .result_i(result_o), .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .pending_o(pending), .errors_o(errors)
  );

  // Nothing accepted and no result for too long means the block has hung.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_request(sgd_req_t r);
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic wait_quiet();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy_o);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_count(logic idx, logic [CNT_REG_W-1:0] v);
    wait_quiet();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic sgd_req_t add_request(logic [31:0] size);
    sgd_req_t r;
    r.cmd       = CMD_ADD;
    r.seg_index = 4'($urandom);
    r.seg_addr  = 48'({$urandom, $urandom});
    r.seg_len   = $urandom;
    r.req_size  = size;
    return r;
  endfunction

  // Segment load; wide picks full-width random contents, otherwise small lengths.
  function automatic sgd_req_t seg_load(sgd_cmd_e c, int idx, bit wide);
    sgd_req_t r;
    r = add_request($urandom);
    r.cmd = c;
    r.seg_index = 4'(idx);
    if (!wide) begin
      if (c == CMD_LOAD_DATA) r.seg_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 600);
      else r.seg_len = $urandom_range(0, 1500);
    end
    return r;
  endfunction

  task automatic load_tables(bit wide);
    for (int i = 0; i < 16; i++) begin
      send_request(seg_load(CMD_LOAD_DATA, i, wide));
      send_request(seg_load(CMD_LOAD_DESC, i, wide));
    end
  endtask

  function automatic logic [31:0] random_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return 0;
    if (pick < 20) return $urandom;
    if (pick < 30) return $urandom_range(1, 64);
    return $urandom_range(1, 3000);
  endfunction

  task automatic run_phase(int n, int idle_pct, bit wide);
    int pick;
    sgd_req_t r;
    for (int k = 0; k < n; k++) begin
      while ($urandom_range(0, 99) < idle_pct) begin
        start_i <= 1'b0;
        @(posedge clk_i);
      end
      if (k == n / 2) wait_quiet();
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        r = seg_load(pick[0] ? CMD_LOAD_DESC : CMD_LOAD_DATA, $urandom_range(0, 15),
                     wide || ($urandom_range(0, 4) == 0));
      end else if (pick < 20) begin
        r = add_request(0);
        r.cmd = CMD_CLEAR;
      end else begin
        r = add_request(random_size());
      end
      send_request(r);
    end
  endtask

  initial begin
    sgd_req_t r;
    start_i     <= 1'b0;
    req_i       <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_DATA_COUNT;
    cfg_wdata_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty tables: the data side is full at once, and a zero size is refused.
    send_request(add_request(5));
    send_request(add_request(0));
    load_tables(1'b0);
    write_count(CFG_DATA_COUNT, 5'd16);
    write_count(CFG_DESC_COUNT, 5'd16);
    send_request(add_request(1));
    send_request(add_request(100));
    send_request(add_request(4000));
    send_request(add_request(32'hFFFF_FFFF));
    r = add_request(0);
    r.cmd = CMD_CLEAR;
    send_request(r);
    // Counts above the table depth saturate.
    write_count(CFG_DATA_COUNT, 5'd31);
    write_count(CFG_DESC_COUNT, 5'd31);
    send_request(add_request(2500));
    // No descriptor area at all, then one too short for a descriptor.
    write_count(CFG_DESC_COUNT, 5'd0);
    send_request(add_request(10));
    r = seg_load(CMD_LOAD_DESC, 0, 1'b0);
    r.seg_addr = 48'h1;
    r.seg_len = 32'd40;
    send_request(r);
    write_count(CFG_DESC_COUNT, 5'd1);
    send_request(add_request(10));
    // Huge segments: the slot address in the descriptor area wraps, and the data offset passes 32 bits.
    r = seg_load(CMD_LOAD_DESC, 0, 1'b0);
    r.seg_addr = 48'hFFFF_FFFF_FFFF;
    r.seg_len = 32'hFFFF_FFFF;
    send_request(r);
    r.cmd = CMD_LOAD_DATA;
    send_request(r);
    r.seg_index = 4'd1;
    send_request(r);
    r.cmd = CMD_CLEAR;
    send_request(r);
    write_count(CFG_DATA_COUNT, 5'd2);
    send_request(add_request(32'hFFFF_FFFF));
    send_request(add_request(2));

    for (int ph = 0; ph < 4; ph++) begin
      load_tables(ph == 2);
      write_count(CFG_DATA_COUNT, (ph == 3) ? 5'd1 : 5'($urandom_range(8, 31)));
      write_count(CFG_DESC_COUNT, (ph == 1) ? 5'd16 : 5'($urandom_range(1, 31)));
      case (ph)
        0: run_phase(40, 0, 1'b0);
        1: run_phase(40, 58, 1'b0);
        2: run_phase(30, 0, 1'b1);
        default: run_phase(40, 8, 1'b0);
      endcase
    end

    wait_quiet();
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/sgd_pkg.sv
rtl/sgd_ram.sv
rtl/sg_descriptor_builder.sv
bench/sg_descriptor_builder_checker.sv
bench/sg_descriptor_builder_tb.sv
